// File: rtl/core/ipv6p_pkg.sv
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Shared types, codes and per-character parse step for the IPv6 text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6p_pkg;

  localparam int MAX_TEXT_LEN_DEF = 66;
  localparam int POS_W = 7;
  localparam logic [16:0] ACC_MAX = 17'h1FFFF;

  // error codes
  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_CLASS     = 4'd1;
  localparam logic [3:0] E_CHAR      = 4'd2;
  localparam logic [3:0] E_LONG      = 4'd3;
  localparam logic [3:0] E_BRACKET   = 4'd4;
  localparam logic [3:0] E_GCOUNT    = 4'd5;
  localparam logic [3:0] E_GRANGE    = 4'd6;
  localparam logic [3:0] E_OCOUNT    = 4'd7;
  localparam logic [3:0] E_ORANGE    = 4'd8;
  localparam logic [3:0] E_V4SPACE   = 4'd9;
  localparam logic [3:0] E_V4POS     = 4'd10;
  localparam logic [3:0] E_ZRUN      = 4'd11;
  localparam logic [3:0] E_PREFIX    = 4'd12;
  localparam logic [3:0] E_PORT      = 4'd13;
  localparam logic [3:0] E_V4INC     = 4'd14;
  localparam logic [3:0] E_NONDEC    = 4'd15;

  typedef enum logic [7:0] {
    PH_NONE  = 8'b0000_0001,
    PH_ADDR  = 8'b0000_0010,
    PH_SEP   = 8'b0000_0100,
    PH_CIDR  = 8'b0000_1000,
    PH_IFACE = 8'b0001_0000,
    PH_PORT  = 8'b0010_0000,
    PH_POST  = 8'b0100_0000,
    PH_ERR   = 8'b1000_0000
  } phase_t;

  typedef enum logic [3:0] {
    C_DIG, C_HEX, C_V4, C_V6, C_CIDR, C_IFACE, C_OPEN, C_CLOSE, C_WS, C_BAD
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } chr_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [15:0] port;
    logic        has_prefix;
    logic        has_port;
    logic        ipv4_embedded;
    logic        ok;
    logic [3:0]  error_code;
  } res_t;

  // parse state carried from front to back
  typedef struct packed {
    phase_t            phase;
    logic [7:0][15:0]  groups;
    logic [3:0]        gcnt;
    logic [3:0]        zri;
    logic              zrs;
    logic [3:0]        v4b;
    logic [2:0]        v4c;
    logic              v4m;
    logic [16:0]       hex;
    logic [16:0]       dec;
    logic              letter;
    logic [1:0]        bracket;
    logic [7:0]        prefix;
    logic              pseen;
    logic [15:0]       port;
    logic              portseen;
    logic [3:0]        ferr;
  } st_t;

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    if (c >= 8'h30 && c <= 8'h39) r = C_DIG;
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) r = C_HEX;
    else begin
      case (c)
        8'h3a: r = C_V6;
        8'h2e: r = C_V4;
        8'h2f: r = C_CIDR;
        8'h25: r = C_IFACE;
        8'h5b: r = C_OPEN;
        8'h5d: r = C_CLOSE;
        8'h20, 8'h09, 8'h0a, 8'h0d: r = C_WS;
        default: r = C_BAD;
      endcase
    end
    return r;
  endfunction

  function automatic void fail(inout st_t s, input logic [3:0] code);
    if (s.ferr == E_NONE) s.ferr = code;
    s.phase = PH_ERR;
  endfunction

  function automatic void add_dec(inout st_t s, input logic [7:0] c);
    logic [20:0] v;
    v = {4'b0, s.dec} * 21'd10 + {13'b0, c - 8'h30};
    s.dec = (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[16:0];
  endfunction

  function automatic void add_char(inout st_t s, input logic [7:0] c);
    logic [7:0]  d;
    logic [20:0] v;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else d = c - 8'h37;
    v = {s.hex, 4'b0} | {17'b0, d[3:0]};
    s.hex = (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[16:0];
    if (c >= 8'h30 && c <= 8'h39) add_dec(s, c);
    else s.letter = 1'b1;
  endfunction

  function automatic void start_token(inout st_t s, input logic [7:0] c);
    s.phase  = PH_ADDR;
    s.hex    = '0;
    s.dec    = '0;
    s.letter = 1'b0;
    add_char(s, c);
  endfunction

  function automatic void start_dec(inout st_t s, input phase_t ph);
    s.phase = ph;
    s.dec   = '0;
  endfunction

  // store finished address token, 1 when no error raised
  function automatic logic take_comp(inout st_t s);
    logic [3:0] idx;
    logic [3:0] half;
    if (s.v4m) begin
      if (s.letter) begin fail(s, E_NONDEC); return 1'b0; end
      if (s.v4c >= 3'd4) begin fail(s, E_OCOUNT); return 1'b0; end
      if (s.dec > 17'hFF) begin fail(s, E_ORANGE); return 1'b0; end
      if (s.v4b > 4'd6) begin fail(s, E_V4SPACE); return 1'b0; end
      half = {2'b0, s.v4c[2:1]};
      idx  = s.v4b + half;
      if (!s.v4c[0]) s.groups[idx[2:0]][15:8] = s.dec[7:0];
      else s.groups[idx[2:0]][7:0] = s.dec[7:0];
      s.v4c = s.v4c + 3'd1;
      return 1'b1;
    end
    if (s.gcnt >= 4'd8) begin fail(s, E_GCOUNT); return 1'b0; end
    if (s.hex > 17'hFFFF) begin fail(s, E_GRANGE); return 1'b0; end
    s.groups[s.gcnt[2:0]] = s.hex[15:0];
    s.gcnt = s.gcnt + 4'd1;
    return 1'b1;
  endfunction

  function automatic void take_prefix_to(inout st_t s, input phase_t ph);
    if (s.dec >= 17'd129) fail(s, E_PREFIX);
    else begin
      s.prefix = s.dec[7:0];
      s.pseen  = 1'b1;
      s.phase  = ph;
    end
  endfunction

  // one character of the phase machine
  function automatic st_t advance(st_t s_in, cls_t cls, logic [7:0] c);
    st_t s;
    s = s_in;
    unique case (s.phase)
      PH_NONE: begin
        if (cls == C_DIG || cls == C_HEX) start_token(s, c);
        else if (cls == C_OPEN) begin
          if (s.bracket != 2'd1) fail(s, E_BRACKET);
        end
        else if (cls == C_CLOSE) s.phase = PH_POST;
        else if (cls == C_V6) s.phase = PH_SEP;
        else if (cls == C_CIDR) start_dec(s, PH_CIDR);
        else if (cls != C_WS) fail(s, E_CLASS);
      end
      PH_ADDR: begin
        if (cls == C_DIG || cls == C_HEX) add_char(s, c);
        else if (cls == C_CLOSE) begin
          if (take_comp(s)) s.phase = PH_POST;
        end
        else if (cls == C_WS) begin
          if (take_comp(s)) s.phase = PH_NONE;
        end
        else if (cls == C_V6) begin
          if (s.v4m) fail(s, E_V4POS);
          else if (take_comp(s)) s.phase = PH_SEP;
        end
        else if (cls == C_V4) begin
          if (!s.v4m && s.gcnt >= 4'd7) begin
            s.v4b = s.gcnt;
            s.v4m = 1'b1;
            fail(s, E_V4SPACE);
          end else begin
            if (!s.v4m) begin
              s.v4b  = s.gcnt;
              s.v4m  = 1'b1;
              s.gcnt = s.gcnt + 4'd2;
            end
            if (take_comp(s)) s.phase = PH_NONE;
          end
        end
        else if (cls == C_IFACE) begin
          if (take_comp(s)) s.phase = PH_IFACE;
        end
        else if (cls == C_CIDR) begin
          if (take_comp(s)) start_dec(s, PH_CIDR);
        end
        else fail(s, E_CLASS);
      end
      PH_SEP: begin
        if (cls == C_V6) begin
          if (s.zrs) fail(s, E_ZRUN);
          else begin
            s.zri   = s.gcnt;
            s.zrs   = 1'b1;
            s.phase = PH_NONE;
          end
        end
        else if (cls == C_WS) s.phase = PH_NONE;
        else if (cls == C_DIG || cls == C_HEX) start_token(s, c);
        else if (cls == C_IFACE) s.phase = PH_IFACE;
        else if (cls == C_CIDR) start_dec(s, PH_CIDR);
        else fail(s, E_CLASS);
      end
      PH_IFACE: begin
        if (cls == C_WS) s.phase = PH_NONE;
        else if (cls == C_CLOSE) s.phase = PH_POST;
      end
      PH_CIDR: begin
        if (cls == C_DIG) add_dec(s, c);
        else if (cls == C_CLOSE) take_prefix_to(s, PH_POST);
        else if (cls == C_WS) take_prefix_to(s, PH_NONE);
        else if (cls == C_IFACE) take_prefix_to(s, PH_IFACE);
        else fail(s, E_CLASS);
      end
      PH_POST: begin
        if (cls == C_V6) start_dec(s, PH_PORT);
        else if (cls != C_WS) fail(s, E_CLASS);
      end
      PH_PORT: begin
        if (cls == C_DIG) add_dec(s, c);
        else if (cls == C_WS) begin
          if (s.dec > 17'hFFFF) fail(s, E_PORT);
          else begin
            s.port     = s.dec[15:0];
            s.portseen = 1'b1;
            s.phase    = PH_NONE;
          end
        end
        else fail(s, E_CLASS);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic st_t st_clear();
    st_t s;
    s = '0;
    s.phase = PH_NONE;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipv6p_queue.sv
// ----------------------------------------------------------------------------
// ipv6p_queue
// Two-entry queue of fixed width beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ipv6p_front.sv
// ----------------------------------------------------------------------------
// ipv6p_front
// Per-character classification and parse state; hands off state at string end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_front
  import ipv6p_pkg::*;
#(
  parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire chr_t item,
  output logic      rec_push,
  output st_t       rec
);

  st_t             st;
  st_t             st_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic            ended;
  logic            ended_next;
  logic            tempty;
  logic            tempty_next;
  cls_t            cls;

  assign cls = classify(item.ch);

  // next parse state for this beat
  always_comb begin
    st_next     = st;
    pos_next    = pos;
    ended_next  = ended;
    tempty_next = tempty;
    if (pos >= POS_W'(MAX_TEXT_LEN)) begin
      if (!tempty) begin
        st_next.ferr  = E_LONG;
        st_next.phase = PH_ERR;
      end
    end else begin
      pos_next = pos + POS_W'(1);
    end
    if (!ended && st_next.phase != PH_ERR) begin
      if (item.ch == 8'h00) begin
        ended_next = 1'b1;
        if (pos == '0) begin
          tempty_next = 1'b1;
          fail(st_next, E_CLASS);
        end
      end else begin
        if (cls == C_OPEN && st_next.bracket < 2'd3)
          st_next.bracket = st_next.bracket + 2'd1;
        if (cls == C_BAD) fail(st_next, E_CHAR);
        else st_next = advance(st_next, cls, item.ch);
      end
    end
  end

  assign rec      = st_next;
  assign rec_push = take && item.last;

  // parse registers, cleared after each string
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= st_clear();
      pos    <= '0;
      ended  <= 1'b0;
      tempty <= 1'b0;
    end else if (take) begin
      if (item.last) begin
        st     <= st_clear();
        pos    <= '0;
        ended  <= 1'b0;
        tempty <= 1'b0;
      end else begin
        st     <= st_next;
        pos    <= pos_next;
        ended  <= ended_next;
        tempty <= tempty_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ipv6p_back.sv
// ----------------------------------------------------------------------------
// ipv6p_back
// End-of-string checks, zero run expansion and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_back
  import ipv6p_pkg::*;
(
  input  wire st_t rec,
  output res_t     res
);

  st_t              s;
  logic             ok;
  logic [3:0]       cnt;
  logic [3:0]       zri_c;
  logic [3:0]       move;
  logic [3:0]       target;
  logic [3:0]       src;
  logic [7:0][15:0] dst;

  always_comb begin
    // end of text acts as whitespace
    s = rec;
    if (s.phase != PH_ERR) s = advance(s, C_WS, 8'h20);
    if (s.phase != PH_ERR && s.v4m && s.v4c != 3'd4) fail(s, E_V4INC);
    if (s.phase != PH_ERR && !s.zrs && s.gcnt < 4'd8) fail(s, E_GCOUNT);
    ok = (s.phase != PH_ERR) && (s.ferr == E_NONE);

    // zero run expansion
    cnt    = (s.gcnt > 4'd8) ? 4'd8 : s.gcnt;
    zri_c  = (s.zri > cnt) ? cnt : s.zri;
    move   = cnt - zri_c;
    target = 4'd8 - move;
    dst    = '0;
    for (int j = 0; j < 8; j++) begin
      src = 4'(j) + cnt - 4'd8;
      if (!ok) dst[7-j] = '0;
      else if (!s.zrs) dst[7-j] = s.groups[j];
      else if (4'(j) < zri_c) dst[7-j] = s.groups[j];
      else if (4'(j) >= target) dst[7-j] = s.groups[src[2:0]];
      else dst[7-j] = '0;
    end

    res.addr_hi       = dst[7:4];
    res.addr_lo       = dst[3:0];
    res.prefix_len    = (ok && s.pseen) ? s.prefix : 8'd0;
    res.port          = (ok && s.portseen) ? s.port : 16'd0;
    res.has_prefix    = ok && s.pseen;
    res.has_port      = ok && s.portseen;
    res.ipv4_embedded = ok && s.v4m;
    res.ok            = ok;
    res.error_code    = ok ? E_NONE : s.ferr;
  end

endmodule

`default_nettype wire

// File: rtl/core/ipv6_text_address_parser_unit.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_unit
// IPv6 text address parser: one character per beat, one result per string.
// ----------------------------------------------------------------------------
// Input channel: item (ch, last) is taken when push is high and full is low.
// One character is taken per cycle while full is low; the front parser
// updates its state in the cycle of the beat. The beat marked last closes
// the string: the state is written into a two-entry hand-off queue and the
// parser clears itself, so the next string may start in the following cycle.
// The back stage combinationally finishes the string (end checks, zero run
// expansion) and writes the result into a two-entry result queue. A result
// is on result while empty is low and leaves when pop is high.
// State waits in the hand-off queue, then the result in the result queue.
// Throughput: one character per cycle while full is low, bounded by the
// per-character parse step of the front stage.
// If the receiver stalls, both queues fill and full rises; input beats wait.
// Reset (rst, synchronous) empties both queues and clears the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_text_address_parser_unit
  import ipv6p_pkg::*;
#(
  parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire chr_t item,
  output logic      empty,
  input  wire logic pop,
  output res_t      result
);

  logic rec_push;
  st_t  rec_in;
  st_t  rec_out;
  logic mid_full;
  logic mid_empty;
  logic res_full;
  res_t res_comb;
  logic move_beat;

  assign full      = mid_full;
  assign move_beat = !mid_empty && !res_full;

  ipv6p_front #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (push && !mid_full),
    .item     (item),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  ipv6p_queue #(
    .WIDTH($bits(st_t))
  ) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (mid_full),
    .pop   (move_beat),
    .rdata (rec_out),
    .empty (mid_empty)
  );

  ipv6p_back u_back (
    .rec (rec_out),
    .res (res_comb)
  );

  ipv6p_queue #(
    .WIDTH($bits(res_t))
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (move_beat),
    .wdata (res_comb),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

// File: sim/tb_ipv6_text_address_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_ipv6_text_address_parser_unit
// Self-checking bench for the IPv6 text parser. Strings go in one character
// per beat; a behavioral parser predicts each result and a monitor compares
// every popped result against the oldest prediction, with random gaps on
// both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv6_text_address_parser_unit;
  import ipv6p_pkg::*;

  localparam int TEXT_LIMIT = MAX_TEXT_LEN_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  // predictor phases
  typedef enum int {P_NONE, P_ADDR, P_SEP, P_CIDR, P_IFACE, P_PORT, P_POST, P_ERR} pph_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  chr_t item;
  logic empty;
  logic pop;
  res_t result;

  ipv6_text_address_parser_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  // parser state of the predictor
  pph_t        ph;
  logic [15:0] grp [8];
  int unsigned gcnt, zri, zrs, v4b, v4c, v4m, hexa, deca, letter;
  int unsigned cpos, brk, pfx, pseen, prt, prtseen, ferr, ended, empty_txt;

  res_t        exp_results[$];
  int          mismatch_count;
  int          fail_count;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_parse();
    ph = P_NONE;
    for (int i = 0; i < 8; i++) grp[i] = '0;
    gcnt = 0; zri = 0; zrs = 0; v4b = 0; v4c = 0; v4m = 0;
    hexa = 0; deca = 0; letter = 0; cpos = 0; brk = 0;
    pfx = 0; pseen = 0; prt = 0; prtseen = 0; ferr = 0; ended = 0; empty_txt = 0;
  endfunction

  function automatic void raise_err(int unsigned code);
    if (ferr == 0) ferr = code;
    ph = P_ERR;
  endfunction

  function automatic cls_t char_class(logic [7:0] c);
    if (c >= "0" && c <= "9") return C_DIG;
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return C_HEX;
    case (c)
      ":": return C_V6;
      ".": return C_V4;
      "/": return C_CIDR;
      "%": return C_IFACE;
      "[": return C_OPEN;
      "]": return C_CLOSE;
      8'h20, 8'h09, 8'h0a, 8'h0d: return C_WS;
      default: return C_BAD;
    endcase
  endfunction

  function automatic void dec_digit(logic [7:0] c);
    int unsigned v;
    v = deca * 10 + (c - "0");
    deca = (v > 'h1FFFF) ? 'h1FFFF : v;
  endfunction

  function automatic void hex_digit(logic [7:0] c);
    int unsigned d, v;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else d = c - "A" + 10;
    v = (hexa << 4) | d;
    hexa = (v > 'h1FFFF) ? 'h1FFFF : v;
    if (c >= "0" && c <= "9") dec_digit(c);
    else letter = 1;
  endfunction

  function automatic void open_token(logic [7:0] c);
    ph = P_ADDR; hexa = 0; deca = 0; letter = 0;
    hex_digit(c);
  endfunction

  function automatic void open_dec(pph_t p);
    ph = p; deca = 0;
  endfunction

  function automatic bit store_token();
    int unsigned idx;
    if (v4m) begin
      if (letter) begin raise_err(E_NONDEC); return 0; end
      if (v4c >= 4) begin raise_err(E_OCOUNT); return 0; end
      if (deca > 'hFF) begin raise_err(E_ORANGE); return 0; end
      if (v4b > 6) begin raise_err(E_V4SPACE); return 0; end
      idx = (v4b + (v4c >> 1)) & 7;
      if ((v4c & 1) == 0) grp[idx][15:8] = deca[7:0];
      else grp[idx][7:0] = deca[7:0];
      v4c++;
      return 1;
    end
    if (gcnt >= 8) begin raise_err(E_GCOUNT); return 0; end
    if (hexa > 'hFFFF) begin raise_err(E_GRANGE); return 0; end
    grp[gcnt & 7] = hexa[15:0];
    gcnt++;
    return 1;
  endfunction

  function automatic bit store_prefix();
    if (deca >= 129) begin raise_err(E_PREFIX); return 0; end
    pfx = deca; pseen = 1;
    return 1;
  endfunction

  function automatic void parse_char(cls_t cls, logic [7:0] c);
    case (ph)
      P_NONE: begin
        if (cls == C_DIG || cls == C_HEX) open_token(c);
        else if (cls == C_OPEN) begin
          if (brk != 1) raise_err(E_BRACKET);
        end
        else if (cls == C_CLOSE) ph = P_POST;
        else if (cls == C_V6) ph = P_SEP;
        else if (cls == C_CIDR) open_dec(P_CIDR);
        else if (cls != C_WS) raise_err(E_CLASS);
      end
      P_ADDR: begin
        if (cls == C_DIG || cls == C_HEX) hex_digit(c);
        else if (cls == C_CLOSE) begin
          if (store_token()) ph = P_POST;
        end
        else if (cls == C_WS) begin
          if (store_token()) ph = P_NONE;
        end
        else if (cls == C_V6) begin
          if (v4m) raise_err(E_V4POS);
          else if (store_token()) ph = P_SEP;
        end
        else if (cls == C_V4) begin
          if (!v4m) begin
            v4b = gcnt; v4m = 1;
            if (gcnt >= 7) begin
              raise_err(E_V4SPACE);
              return;
            end
            gcnt += 2;
          end
          if (store_token()) ph = P_NONE;
        end
        else if (cls == C_IFACE) begin
          if (store_token()) ph = P_IFACE;
        end
        else if (cls == C_CIDR) begin
          if (store_token()) open_dec(P_CIDR);
        end
        else raise_err(E_CLASS);
      end
      P_SEP: begin
        if (cls == C_V6) begin
          if (zrs) raise_err(E_ZRUN);
          else begin
            zri = gcnt; zrs = 1; ph = P_NONE;
          end
        end
        else if (cls == C_WS) ph = P_NONE;
        else if (cls == C_DIG || cls == C_HEX) open_token(c);
        else if (cls == C_IFACE) ph = P_IFACE;
        else if (cls == C_CIDR) open_dec(P_CIDR);
        else raise_err(E_CLASS);
      end
      P_IFACE: begin
        if (cls == C_WS) ph = P_NONE;
        else if (cls == C_CLOSE) ph = P_POST;
      end
      P_CIDR: begin
        if (cls == C_DIG) dec_digit(c);
        else if (cls == C_CLOSE) begin
          if (store_prefix()) ph = P_POST;
        end
        else if (cls == C_WS) begin
          if (store_prefix()) ph = P_NONE;
        end
        else if (cls == C_IFACE) begin
          if (store_prefix()) ph = P_IFACE;
        end
        else raise_err(E_CLASS);
      end
      P_POST: begin
        if (cls == C_V6) open_dec(P_PORT);
        else if (cls != C_WS) raise_err(E_CLASS);
      end
      P_PORT: begin
        if (cls == C_DIG) dec_digit(c);
        else if (cls == C_WS) begin
          if (deca > 'hFFFF) raise_err(E_PORT);
          else begin
            prt = deca; prtseen = 1; ph = P_NONE;
          end
        end
        else raise_err(E_CLASS);
      end
      default: ;
    endcase
  endfunction

  // end of string: checks, zero run expansion, result
  function automatic res_t close_string();
    res_t r;
    logic [15:0] dst [8];
    bit good;
    int unsigned cnt, zi, mv, tgt;
    if (ph != P_ERR) parse_char(C_WS, 8'h20);
    if (ph != P_ERR && v4m && v4c != 4) raise_err(E_V4INC);
    if (ph != P_ERR && !zrs && gcnt < 8) raise_err(E_GCOUNT);
    good = (ph != P_ERR) && (ferr == 0);
    for (int i = 0; i < 8; i++) dst[i] = '0;
    if (good) begin
      if (zrs) begin
        cnt = (gcnt > 8) ? 8 : gcnt;
        zi = (zri > cnt) ? cnt : zri;
        mv = cnt - zi;
        tgt = 8 - mv;
        for (int i = 0; i < zi; i++) dst[i & 7] = grp[i & 7];
        for (int i = 0; i < mv; i++) dst[(tgt + i) & 7] = grp[(zi + i) & 7];
      end else begin
        for (int i = 0; i < 8; i++) dst[i] = grp[i];
      end
    end
    r.addr_hi = {dst[0], dst[1], dst[2], dst[3]};
    r.addr_lo = {dst[4], dst[5], dst[6], dst[7]};
    r.prefix_len = (good && pseen) ? pfx[7:0] : 8'd0;
    r.port = (good && prtseen) ? prt[15:0] : 16'd0;
    r.has_prefix = good && pseen;
    r.has_port = good && prtseen;
    r.ipv4_embedded = good && v4m;
    r.ok = good;
    r.error_code = good ? E_NONE : ferr[3:0];
    return r;
  endfunction

  function automatic void predict_char(logic [7:0] c, logic lst);
    int unsigned pos;
    cls_t cls;
    pos = cpos;
    if (pos >= TEXT_LIMIT) begin
      if (!empty_txt) begin ferr = E_LONG; ph = P_ERR; end
    end else cpos = pos + 1;
    if (!ended && ph != P_ERR) begin
      if (c == 0) begin
        ended = 1;
        if (pos == 0) begin empty_txt = 1; raise_err(E_CLASS); end
      end else begin
        cls = char_class(c);
        if (cls == C_OPEN && brk < 3) brk++;
        if (cls == C_BAD) raise_err(E_CHAR);
        else parse_char(cls, c);
      end
    end
    if (lst) begin
      exp_results.push_back(close_string());
      clear_parse();
    end
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // one beat into the block
  task automatic send_char(logic [7:0] c, logic lst);
    int g;
    g = gap_len();
    repeat (g) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{ch: c, last: lst};
    @(posedge clk);
    while (full) @(posedge clk);
    predict_char(c, lst);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    if (s.len() == 0) send_char(8'h00, 1'b1);
  endtask

  task automatic drain_wait();
    push <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random pick from an alphabet biased to parse well
  function automatic string rand_piece();
    string hx;
    int n;
    hx = "0123456789abcdefABCDEF";
    rand_piece = "";
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 30) == 0) n = $urandom_range(5, 7);
    for (int i = 0; i < n; i++) rand_piece = {rand_piece, hx.substr($urandom_range(0, 21), $urandom_range(0, 21))};
  endfunction

  function automatic string hex_group();
    string hx;
    int n;
    hx = "0123456789abcdefABCDEF";
    hex_group = "";
    n = ($urandom_range(0, 30) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      int j;
      j = $urandom_range(0, 21);
      hex_group = {hex_group, hx.substr(j, j)};
    end
  endfunction

  function automatic string dotted_quad();
    dotted_quad = "";
    for (int i = 0; i < 4; i++) begin
      int v;
      v = ($urandom_range(0, 20) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
      if (i != 0) dotted_quad = {dotted_quad, "."};
      dotted_quad = {dotted_quad, $sformatf("%0d", v)};
    end
  endfunction

  function automatic string well_formed();
    string s;
    int n, zpos, v4;
    v4 = ($urandom_range(0, 3) == 0);
    n = v4 ? 6 : 8;
    zpos = ($urandom_range(0, 1)) ? $urandom_range(0, n) : -1;
    s = "";
    if (zpos >= 0) begin
      int keep;
      keep = $urandom_range(0, n - 1);
      for (int i = 0; i < keep; i++) begin
        if (i == zpos) s = {s, "::"};
        else if (i != 0) s = {s, ":"};
        s = {s, hex_group()};
      end
      if (zpos >= keep) s = {s, "::"};
      else if (v4 && keep > 0) s = {s, ":"};
    end else begin
      for (int i = 0; i < n; i++) begin
        if (i != 0) s = {s, ":"};
        s = {s, hex_group()};
      end
      if (v4) s = {s, ":"};
    end
    if (v4) s = {s, dotted_quad()};
    if ($urandom_range(0, 4) == 0) s = {s, "%eth", $sformatf("%0d", $urandom_range(0, 9))};
    if ($urandom_range(0, 3) == 0) s = {s, "/", $sformatf("%0d", $urandom_range(0, 140))};
    if ($urandom_range(0, 4) == 0)
      s = {"[", s, "]", ($urandom_range(0, 2) != 0) ? $sformatf(":%0d", $urandom_range(0, 70000)) : ""};
    return s;
  endfunction

  // mutate a good string: overwrite random bytes, or cut it at a random byte and end it in a colon
  function automatic string broken(string s);
    string t;
    string marks;
    t = s;
    marks = ":.[]/% 0fA";
    repeat ($urandom_range(1, 3)) begin
      int p;
      byte b;
      b = byte'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) b = marks[$urandom_range(0, 9)];
      if (t.len() == 0) t = " ";
      p = $urandom_range(0, t.len() - 1);
      if (b != 0) t[p] = b;
      else t = {t.substr(0, p - 1), ":"};
    end
    return t;
  endfunction

  task automatic test_directed();
    send_text("::");
    send_text("::1");
    send_text("1:2:3:4:5:6:7:8");
    send_text("FFFF:ffff:0:0:0:0:0:FFFF");
    send_text("::ffff:192.168.1.255");
    send_text("1:2:3:4:5:6:1.2.3.4");
    send_text("fe80::1%eth0");
    send_text("2001:db8::/128");
    send_text("2001:db8::/129");
    send_text("[2001:db8::1]:65535");
    send_text("[::1]:65536");
    send_text("[::1]:");
    send_text("1::2::3");
    send_text("1:2:3:4:5:6:7:1.2.3.4");
    send_text("::1.2.3");
    send_text("::1.2.3.a");
    send_text("::1.2.3.4.5");
    send_text("::300.1.1.1");
    send_text("::1.2.3.4:5");
    send_text("12345::");
    send_text("1:2:3");
    send_text("1:2:3:4:5:6:7:8:9");
    send_text("[[::1]");
    send_text("::1@");
    send_text("");
    send_char(8'h00, 1'b0); send_char(8'h41, 1'b1);
    send_text("::1/");
    send_text("::1 x");
    send_text("1:2:3:4:5:6:7:8/64/32");
    send_text("0000:0000:0000:0000:0000:0000:0000:00000000000000000000000000000000000");
  endtask

  task automatic test_extremes();
    // every ch bit both ways, text after a terminator, and an overlong string
    for (int b = 0; b < 8; b++) begin
      send_char(8'(1 << b), 1'b0);
      send_char(8'hFF ^ 8'(1 << b), 1'b1);
    end
    send_text("::1");
    send_char(8'h00, 1'b0);
    repeat (80) send_char(8'(($urandom_range(1, 255))), 1'b0);
    send_char(8'h31, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int sent;
    string s;
    sent = 0;
    while (sent < n_items) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 70) s = well_formed();
      else if (k < 90) s = broken(well_formed());
      else begin
        s = "";
        repeat ($urandom_range(0, 12)) s = {s, rand_piece()};
        if ($urandom_range(0, 3) == 0) s = {s, ":"};
      end
      if ($urandom_range(0, 15) == 0) begin
        // terminator inside, trailing bytes only counted
        s = {s, " "};
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
        sent += s.len() + 2;
      end else begin
        send_text(s);
        sent += (s.len() == 0) ? 1 : s.len();
      end
      if ($urandom_range(0, 60) == 0) drain_wait();
    end
  endtask

  // result side: random pop gaps, compare against oldest prediction
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        res_t e;
        if (exp_results.size() == 0) begin
          fail_count++;
          if (mismatch_count < 10) $display("unexpected result beat: %p", result);
          mismatch_count++;
        end else begin
          e = exp_results.pop_front();
          if (result !== e) begin
            fail_count++;
            if (mismatch_count < 10)
              $display("result mismatch: expected %p actual %p", e, result);
            mismatch_count++;
          end
        end
      end
      if ($urandom_range(0, 99) < 30) pop <= 1'b0;
      else if ($urandom_range(0, 199) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else pop <= 1'b1;
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("ipv6_text_address_parser_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    fail_count = 0;
    clear_parse();
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_wait();
    test_extremes();
    drain_wait();
    test_random(1370);
    drain_wait();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && exp_results.size() == 0)
      $display("ipv6_text_address_parser_unit test passed");
    else
      $display("ipv6_text_address_parser_unit test failed");
    $finish;
  end

endmodule
